/* src/kra_pkg.sv */
// ----------------------------------------------------------------------------
// kra_pkg
// Shared types and field widths for the keyed record aggregator.
// ----------------------------------------------------------------------------
package kra_pkg;

    // field widths
    localparam int CODE_W   = 16;
    localparam int TIME_W   = 44;
    localparam int PCT_W    = 7;
    localparam int TEMP_W   = 19;
    localparam int COUNT_W  = 32;
    localparam int PSUM_W   = 39;
    localparam int TSUM_W   = 51;
    localparam int INDEX_W  = 6;

    // one input word as captured at accept
    typedef struct packed {
        logic [CODE_W-1:0] region_code;
        logic [TIME_W-1:0] timestamp_ms;
        logic [PCT_W-1:0]  humidity;
        logic              snow_flag;
        logic [PCT_W-1:0]  cloud_cover;
        logic              lightning_flag;
        logic [TEMP_W-1:0] temperature;
    } rec_t;

    // per-slot aggregate, stored as one wide memory word
    typedef struct packed {
        logic [COUNT_W-1:0] records;
        logic [PSUM_W-1:0]  hum_sum;
        logic [PSUM_W-1:0]  cloud_sum;
        logic [COUNT_W-1:0] snow_cnt;
        logic [COUNT_W-1:0] light_cnt;
        logic [TSUM_W-1:0]  temp_sum;
        logic [TEMP_W-1:0]  hi_temp;
        logic [TIME_W-1:0]  hi_time;
        logic [TEMP_W-1:0]  lo_temp;
        logic [TIME_W-1:0]  lo_time;
    } agg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic done;
        logic out_free;
    } status_t;

endpackage

/* src/kra_ram.sv */
// ----------------------------------------------------------------------------
// kra_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/kra_ctrl.sv */
// ----------------------------------------------------------------------------
// kra_ctrl
// Sequencer: accept a word, scan the code table, then update the slot.
// ----------------------------------------------------------------------------
module kra_ctrl
    import kra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.match || st.done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (st.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/kra_datapath.sv */
// ----------------------------------------------------------------------------
// kra_datapath
// Code table scan, slot memories, saturating update and result register.
// ----------------------------------------------------------------------------
module kra_datapath
    import kra_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  rec_t    in_rec,
    input  cmd_t    cmd,
    output status_t st,
    input  logic    out_ready,
    output logic    out_valid,
    output logic [INDEX_W-1:0] res_index,
    output logic    res_full,
    output agg_t    res_agg
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

    rec_t             key_reg;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]    cmp_ptr_reg, cmp_ptr_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    logic             fresh_reg, fresh_next;
    logic             full_reg, full_next;
    logic             out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] index_reg;
    logic             tfull_reg;
    agg_t             agg_reg;

    logic [CODE_W-1:0] code_rd;
    agg_t              agg_rd;
    agg_t              cur;
    agg_t              upd;
    logic              ptr_live;
    logic              code_we;
    logic              agg_we;
    logic              agg_re;

    logic [COUNT_W:0]  rec_sum;
    logic [PSUM_W:0]   hum_sum;
    logic [PSUM_W:0]   cloud_sum;
    logic [COUNT_W:0]  snow_sum;
    logic [COUNT_W:0]  light_sum;
    logic [TSUM_W:0]   temp_sum;

    // scan status
    assign ptr_live    = (ptr_reg < fill_reg);
    assign st.match    = cmp_vld_reg && (code_rd == key_reg.region_code);
    assign st.done     = !cmp_vld_reg && (ptr_reg == fill_reg);
    assign st.out_free = !out_valid_reg || out_ready;

    // memory controls
    assign code_we = cmd.update && fresh_reg && !full_reg;
    assign agg_we  = cmd.update && !full_reg;
    assign agg_re  = cmd.scan && st.match;

    kra_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_SLOTS)
    ) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (hit_idx_reg),
        .wdata (key_reg.region_code),
        .re    (cmd.scan && ptr_live),
        .raddr (ptr_reg[IW-1:0]),
        .rdata (code_rd)
    );

    kra_ram #(
        .WIDTH ($bits(agg_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_agg_ram (
        .clk   (clk),
        .we    (agg_we),
        .waddr (hit_idx_reg),
        .wdata (upd),
        .re    (agg_re),
        .raddr (cmp_ptr_reg),
        .rdata (agg_rd)
    );

    // starting aggregate for a new slot or the stored one
    always_comb
    begin
        cur = agg_rd;
        if (fresh_reg)
        begin
            cur         = '0;
            cur.lo_temp = '1;
        end
    end

    // saturating sums
    always_comb
    begin
        rec_sum   = {1'b0, cur.records} + (COUNT_W + 1)'(1);
        hum_sum   = {1'b0, cur.hum_sum} + (PSUM_W + 1)'(key_reg.humidity);
        cloud_sum = {1'b0, cur.cloud_sum} + (PSUM_W + 1)'(key_reg.cloud_cover);
        snow_sum  = {1'b0, cur.snow_cnt} + (COUNT_W + 1)'(key_reg.snow_flag);
        light_sum = {1'b0, cur.light_cnt} + (COUNT_W + 1)'(key_reg.lightning_flag);
        temp_sum  = {1'b0, cur.temp_sum} + (TSUM_W + 1)'(key_reg.temperature);

        upd           = cur;
        upd.records   = rec_sum[COUNT_W]  ? '1 : rec_sum[COUNT_W-1:0];
        upd.hum_sum   = hum_sum[PSUM_W]   ? '1 : hum_sum[PSUM_W-1:0];
        upd.cloud_sum = cloud_sum[PSUM_W] ? '1 : cloud_sum[PSUM_W-1:0];
        upd.snow_cnt  = snow_sum[COUNT_W] ? '1 : snow_sum[COUNT_W-1:0];
        upd.light_cnt = light_sum[COUNT_W] ? '1 : light_sum[COUNT_W-1:0];
        upd.temp_sum  = temp_sum[TSUM_W]  ? '1 : temp_sum[TSUM_W-1:0];

        // strict compares; a new slot always takes the minimum
        if (key_reg.temperature > cur.hi_temp)
        begin
            upd.hi_temp = key_reg.temperature;
            upd.hi_time = key_reg.timestamp_ms;
        end
        if (fresh_reg || (key_reg.temperature < cur.lo_temp))
        begin
            upd.lo_temp = key_reg.temperature;
            upd.lo_time = key_reg.timestamp_ms;
        end
    end

    // scan pointer, hit capture and fill count
    always_comb
    begin
        ptr_next       = ptr_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        hit_idx_next   = hit_idx_reg;
        fresh_next     = fresh_reg;
        full_next      = full_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            ptr_next     = '0;
            cmp_vld_next = 1'b0;
        end

        if (cmd.scan)
        begin
            if (ptr_live)
            begin
                ptr_next     = CW'(ptr_reg + 1'b1);
                cmp_vld_next = 1'b1;
                cmp_ptr_next = ptr_reg[IW-1:0];
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end
            if (st.match)
            begin
                hit_idx_next = cmp_ptr_reg;
                fresh_next   = 1'b0;
                full_next    = 1'b0;
            end
            else if (st.done)
            begin
                hit_idx_next = fill_reg[IW-1:0];
                fresh_next   = 1'b1;
                full_next    = (fill_reg == SLOTS_C);
            end
        end

        if (code_we)
        begin
            fill_next = CW'(fill_reg + 1'b1);
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            fresh_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            cmp_vld_reg   <= cmp_vld_next;
            fresh_reg     <= fresh_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_ptr_reg <= cmp_ptr_next;
        hit_idx_reg <= hit_idx_next;
        if (cmd.load)
        begin
            key_reg <= in_rec;
        end
        if (cmd.update)
        begin
            if (full_reg)
            begin
                index_reg <= '0;
                tfull_reg <= 1'b1;
                agg_reg   <= '0;
            end
            else
            begin
                index_reg <= INDEX_W'(hit_idx_reg);
                tfull_reg <= 1'b0;
                agg_reg   <= upd;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res_index = index_reg;
    assign res_full  = tfull_reg;
    assign res_agg   = agg_reg;

    // the table never holds more codes than it has slots
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOTS_C)
        else $error("fill count beyond table size");

    // a result appears only from an update command
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.update))
        else $error("result valid without update");

    // allocating a slot grows the fill count by exactly one
    a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        code_we |=> fill_reg == CW'($past(fill_reg) + 1'b1))
        else $error("slot allocation lost");

    // a dropped word reports an empty aggregate at slot zero
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tfull_reg) |-> (index_reg == '0 && agg_reg.records == '0))
        else $error("dropped word carries data");

endmodule

/* src/keyed_record_aggregator.sv */
// ----------------------------------------------------------------------------
// keyed_record_aggregator: group-by aggregator for region-keyed weather words
// Result: a word waits while the serial code memory scan walks from slot zero
// to its matching slot, or over every filled slot for a new region.
// Flow: one word in flight, the next is taken the cycle after the update;
// a held result stalls the update. Reset clears the fill count, so all slots
// read empty.
// ----------------------------------------------------------------------------
module keyed_record_aggregator
    import kra_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CODE_W-1:0]   region_code,
    input  logic [TIME_W-1:0]   timestamp_ms,
    input  logic [PCT_W-1:0]    humidity,
    input  logic                snow_flag,
    input  logic [PCT_W-1:0]    cloud_cover,
    input  logic                lightning_flag,
    input  logic [TEMP_W-1:0]   temperature,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [INDEX_W-1:0]  slot_index,
    output logic                table_full,
    output logic [COUNT_W-1:0]  record_total,
    output logic [PSUM_W-1:0]   humidity_total,
    output logic [PSUM_W-1:0]   cloud_total,
    output logic [COUNT_W-1:0]  snow_total,
    output logic [COUNT_W-1:0]  lightning_total,
    output logic [TSUM_W-1:0]   temperature_total,
    output logic [TEMP_W-1:0]   highest_temperature,
    output logic [TIME_W-1:0]   highest_time,
    output logic [TEMP_W-1:0]   lowest_temperature,
    output logic [TIME_W-1:0]   lowest_time
);

    rec_t    in_rec;
    cmd_t    cmd;
    status_t st;
    agg_t    res_agg;

    // pack the input word
    always_comb
    begin
        in_rec.region_code    = region_code;
        in_rec.timestamp_ms   = timestamp_ms;
        in_rec.humidity       = humidity;
        in_rec.snow_flag      = snow_flag;
        in_rec.cloud_cover    = cloud_cover;
        in_rec.lightning_flag = lightning_flag;
        in_rec.temperature    = temperature;
    end

    kra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    kra_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_rec    (in_rec),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_index (slot_index),
        .res_full  (table_full),
        .res_agg   (res_agg)
    );

    // unpack the result word
    assign record_total        = res_agg.records;
    assign humidity_total      = res_agg.hum_sum;
    assign cloud_total         = res_agg.cloud_sum;
    assign snow_total          = res_agg.snow_cnt;
    assign lightning_total     = res_agg.light_cnt;
    assign temperature_total   = res_agg.temp_sum;
    assign highest_temperature = res_agg.hi_temp;
    assign highest_time        = res_agg.hi_time;
    assign lowest_temperature  = res_agg.lo_temp;
    assign lowest_time         = res_agg.lo_time;

endmodule

/* tb/keyed_record_aggregator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_aggregator_test
// Self-checking bench for the region-keyed weather aggregator. A queue of
// words (directed corners, then random traffic over a growing pool of region
// codes that runs the table into the full condition) feeds a clocked driver.
// A built-in slot table predicts every aggregate, and a clocked monitor
// checks each result word field by field under random backpressure.
// ----------------------------------------------------------------------------
module keyed_record_aggregator_test;
    import kra_pkg::*;

    localparam int SLOTS          = 64;
    localparam int RANDOM_WORDS   = 1630;
    localparam int NEW_CODE_ODDS  = 12;
    localparam int POOL_CAP       = SLOTS + 8;
    localparam int MAX_GAP        = 12;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int REPORT_LIMIT   = 10;

    localparam bit [63:0] COUNT_TOP = (64'd1 << COUNT_W) - 1;
    localparam bit [63:0] PSUM_TOP  = (64'd1 << PSUM_W) - 1;
    localparam bit [63:0] TSUM_TOP  = (64'd1 << TSUM_W) - 1;
    localparam bit [TEMP_W-1:0] TEMP_TOP = '1;
    localparam bit [TIME_W-1:0] TIME_TOP = '1;

    // one result word as predicted or observed
    typedef struct packed {
        bit [INDEX_W-1:0] slot;
        bit               full;
        bit [COUNT_W-1:0] records;
        bit [PSUM_W-1:0]  hum_sum;
        bit [PSUM_W-1:0]  cloud_sum;
        bit [COUNT_W-1:0] snow_cnt;
        bit [COUNT_W-1:0] light_cnt;
        bit [TSUM_W-1:0]  temp_sum;
        bit [TEMP_W-1:0]  hi_temp;
        bit [TIME_W-1:0]  hi_time;
        bit [TEMP_W-1:0]  lo_temp;
        bit [TIME_W-1:0]  lo_time;
    } tally_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CODE_W-1:0]   region_code = '0;
    logic [TIME_W-1:0]   timestamp_ms = '0;
    logic [PCT_W-1:0]    humidity = '0;
    logic                snow_flag = 1'b0;
    logic [PCT_W-1:0]    cloud_cover = '0;
    logic                lightning_flag = 1'b0;
    logic [TEMP_W-1:0]   temperature = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [INDEX_W-1:0]  slot_index;
    logic                table_full;
    logic [COUNT_W-1:0]  record_total;
    logic [PSUM_W-1:0]   humidity_total;
    logic [PSUM_W-1:0]   cloud_total;
    logic [COUNT_W-1:0]  snow_total;
    logic [COUNT_W-1:0]  lightning_total;
    logic [TSUM_W-1:0]   temperature_total;
    logic [TEMP_W-1:0]   highest_temperature;
    logic [TIME_W-1:0]   highest_time;
    logic [TEMP_W-1:0]   lowest_temperature;
    logic [TIME_W-1:0]   lowest_time;

    // stimulus and expectation stores
    rec_t              word_queue[$];
    bit [CODE_W-1:0]   code_pool[$];
    tally_t            pending_tallies[$];

    // predicted slot table
    bit                tbl_used[SLOTS];
    bit [CODE_W-1:0]   tbl_code[SLOTS];
    bit [COUNT_W-1:0]  tbl_records[SLOTS];
    bit [PSUM_W-1:0]   tbl_hum[SLOTS];
    bit [PSUM_W-1:0]   tbl_cloud[SLOTS];
    bit [COUNT_W-1:0]  tbl_snow[SLOTS];
    bit [COUNT_W-1:0]  tbl_light[SLOTS];
    bit [TSUM_W-1:0]   tbl_tsum[SLOTS];
    bit [TEMP_W-1:0]   tbl_hi[SLOTS];
    bit [TIME_W-1:0]   tbl_hi_time[SLOTS];
    bit [TEMP_W-1:0]   tbl_lo[SLOTS];
    bit [TIME_W-1:0]   tbl_lo_time[SLOTS];

    int          mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    keyed_record_aggregator #(
        .TABLE_SLOTS (SLOTS)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .region_code         (region_code),
        .timestamp_ms        (timestamp_ms),
        .humidity            (humidity),
        .snow_flag           (snow_flag),
        .cloud_cover         (cloud_cover),
        .lightning_flag      (lightning_flag),
        .temperature         (temperature),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .slot_index          (slot_index),
        .table_full          (table_full),
        .record_total        (record_total),
        .humidity_total      (humidity_total),
        .cloud_total         (cloud_total),
        .snow_total          (snow_total),
        .lightning_total     (lightning_total),
        .temperature_total   (temperature_total),
        .highest_temperature (highest_temperature),
        .highest_time        (highest_time),
        .lowest_temperature  (lowest_temperature),
        .lowest_time         (lowest_time)
    );

    // clock
    always #6 clk = ~clk;

    // saturating add, acc never above top
    function automatic bit [63:0] sat_add(bit [63:0] acc, bit [63:0] inc, bit [63:0] top);
        if (inc > top - acc)
        begin
            return top;
        end
        return acc + inc;
    endfunction

    // update the slot table with one accepted word and queue its aggregate
    function automatic void predict_aggregate(rec_t w);
        int     hit;
        int     vacant;
        bit     fresh;
        tally_t t;
        hit = -1;
        vacant = -1;
        fresh = 1'b0;
        t = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (tbl_used[s])
            begin
                if (hit < 0 && tbl_code[s] == w.region_code)
                    hit = s;
            end
            else if (vacant < 0)
            begin
                vacant = s;
            end
        end
        // new region with no room: dropped, all fields zero
        if (hit < 0 && vacant < 0)
        begin
            t.full = 1'b1;
            pending_tallies.push_back(t);
            return;
        end
        // allocate and clear a new slot
        if (hit < 0)
        begin
            hit = vacant;
            fresh = 1'b1;
            tbl_used[hit]    = 1'b1;
            tbl_code[hit]    = w.region_code;
            tbl_records[hit] = '0;
            tbl_hum[hit]     = '0;
            tbl_cloud[hit]   = '0;
            tbl_snow[hit]    = '0;
            tbl_light[hit]   = '0;
            tbl_tsum[hit]    = '0;
            tbl_hi[hit]      = '0;
            tbl_hi_time[hit] = '0;
            tbl_lo[hit]      = TEMP_TOP;
            tbl_lo_time[hit] = '0;
        end
        tbl_records[hit] = COUNT_W'(sat_add(64'(tbl_records[hit]), 64'd1, COUNT_TOP));
        tbl_hum[hit]     = PSUM_W'(sat_add(64'(tbl_hum[hit]), 64'(w.humidity), PSUM_TOP));
        tbl_cloud[hit]   = PSUM_W'(sat_add(64'(tbl_cloud[hit]), 64'(w.cloud_cover),
                                           PSUM_TOP));
        tbl_snow[hit]    = COUNT_W'(sat_add(64'(tbl_snow[hit]), 64'(w.snow_flag),
                                            COUNT_TOP));
        tbl_light[hit]   = COUNT_W'(sat_add(64'(tbl_light[hit]), 64'(w.lightning_flag),
                                            COUNT_TOP));
        tbl_tsum[hit]    = TSUM_W'(sat_add(64'(tbl_tsum[hit]), 64'(w.temperature),
                                           TSUM_TOP));
        // extremes move only on a strict change; first word always sets the low
        if (w.temperature > tbl_hi[hit])
        begin
            tbl_hi[hit]      = w.temperature;
            tbl_hi_time[hit] = w.timestamp_ms;
        end
        if (fresh || w.temperature < tbl_lo[hit])
        begin
            tbl_lo[hit]      = w.temperature;
            tbl_lo_time[hit] = w.timestamp_ms;
        end
        t.slot      = INDEX_W'(hit);
        t.records   = tbl_records[hit];
        t.hum_sum   = tbl_hum[hit];
        t.cloud_sum = tbl_cloud[hit];
        t.snow_cnt  = tbl_snow[hit];
        t.light_cnt = tbl_light[hit];
        t.temp_sum  = tbl_tsum[hit];
        t.hi_temp   = tbl_hi[hit];
        t.hi_time   = tbl_hi_time[hit];
        t.lo_temp   = tbl_lo[hit];
        t.lo_time   = tbl_lo_time[hit];
        pending_tallies.push_back(t);
    endfunction

    function automatic void check_field(string name, bit [63:0] want, bit [63:0] got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected 0x%0h got 0x%0h",
                         results_seen, name, want, got);
        end
    endfunction

    // compare one result word with the oldest expectation
    function automatic void check_aggregate(tally_t got);
        tally_t want;
        if (pending_tallies.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: unexpected word, slot %0d full %0b",
                         results_seen, got.slot, got.full);
            return;
        end
        want = pending_tallies.pop_front();
        check_field("slot_index", 64'(want.slot), 64'(got.slot));
        check_field("table_full", 64'(want.full), 64'(got.full));
        check_field("record_total", 64'(want.records), 64'(got.records));
        check_field("humidity_total", 64'(want.hum_sum), 64'(got.hum_sum));
        check_field("cloud_total", 64'(want.cloud_sum), 64'(got.cloud_sum));
        check_field("snow_total", 64'(want.snow_cnt), 64'(got.snow_cnt));
        check_field("lightning_total", 64'(want.light_cnt), 64'(got.light_cnt));
        check_field("temperature_total", 64'(want.temp_sum), 64'(got.temp_sum));
        check_field("highest_temperature", 64'(want.hi_temp), 64'(got.hi_temp));
        check_field("highest_time", 64'(want.hi_time), 64'(got.hi_time));
        check_field("lowest_temperature", 64'(want.lo_temp), 64'(got.lo_temp));
        check_field("lowest_time", 64'(want.lo_time), 64'(got.lo_time));
    endfunction

    // add a word to the stimulus and track its region code
    function automatic void add_word(bit [CODE_W-1:0] code, bit [TIME_W-1:0] ts,
                                     bit [PCT_W-1:0] hum, bit snow, bit [PCT_W-1:0] cloud,
                                     bit light, bit [TEMP_W-1:0] temp);
        rec_t w;
        bit   known;
        known = 1'b0;
        w.region_code    = code;
        w.timestamp_ms   = ts;
        w.humidity       = hum;
        w.snow_flag      = snow;
        w.cloud_cover    = cloud;
        w.lightning_flag = light;
        w.temperature    = temp;
        word_queue.push_back(w);
        foreach (code_pool[i])
            if (code_pool[i] == code)
                known = 1'b1;
        if (!known && code_pool.size() < POOL_CAP)
            code_pool.push_back(code);
    endfunction

    // sender gap per word, with quiet stretches
    function automatic int draw_gap(int unsigned n);
        if ((n / 128) % 4 == 3)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // receiver stall per result, with quiet stretches
    function automatic int draw_stall(int unsigned n);
        if ((n / 100) % 4 == 1)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        rec_t w;
        bit   took;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            region_code    <= '0;
            timestamp_ms   <= '0;
            humidity       <= '0;
            snow_flag      <= 1'b0;
            cloud_cover    <= '0;
            lightning_flag <= 1'b0;
            temperature    <= '0;
            send_gap = 0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                w.region_code    = region_code;
                w.timestamp_ms   = timestamp_ms;
                w.humidity       = humidity;
                w.snow_flag      = snow_flag;
                w.cloud_cover    = cloud_cover;
                w.lightning_flag = lightning_flag;
                w.temperature    = temperature;
                predict_aggregate(w);
                words_sent <= words_sent + 1;
                send_gap = draw_gap(words_sent);
            end
            // load the next word once the current one is gone
            if (!in_valid || took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    w = word_queue.pop_front();
                    in_valid       <= 1'b1;
                    region_code    <= w.region_code;
                    timestamp_ms   <= w.timestamp_ms;
                    humidity       <= w.humidity;
                    snow_flag      <= w.snow_flag;
                    cloud_cover    <= w.cloud_cover;
                    lightning_flag <= w.lightning_flag;
                    temperature    <= w.temperature;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        tally_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.slot      = slot_index;
                got.full      = table_full;
                got.records   = record_total;
                got.hum_sum   = humidity_total;
                got.cloud_sum = cloud_total;
                got.snow_cnt  = snow_total;
                got.light_cnt = lightning_total;
                got.temp_sum  = temperature_total;
                got.hi_temp   = highest_temperature;
                got.hi_time   = highest_time;
                got.lo_temp   = lowest_temperature;
                got.lo_time   = lowest_time;
                check_aggregate(got);
                results_seen <= results_seen + 1;
                recv_stall = draw_stall(results_seen);
            end
            else if (out_valid && recv_stall > 0)
            begin
                recv_stall--;
            end
            out_ready <= (hold_left == 0) && (recv_stall == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("keyed_record_aggregator_test NOT OK");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        bit [CODE_W-1:0] code;
        bit [TIME_W-1:0] ts;
        bit [PCT_W-1:0]  hum;
        bit [PCT_W-1:0]  cloud;
        bit [TEMP_W-1:0] temp;

        // corners: zero word, all-ones word, ties at both extremes
        add_word(16'h0000, '0, 7'd0, 1'b0, 7'd0, 1'b0, '0);
        add_word(16'h0000, TIME_TOP, 7'd127, 1'b1, 7'd127, 1'b1, TEMP_TOP);
        add_word(16'h0000, 44'h123_4567_89AB, 7'd50, 1'b0, 7'd60, 1'b1, TEMP_TOP);
        add_word(16'h0000, 44'hFED_CBA9_8765, 7'd100, 1'b1, 7'd100, 1'b0, '0);
        // new region at the top of the range, then strictly lower twice
        add_word(16'hFFFF, TIME_TOP, 7'd100, 1'b1, 7'd0, 1'b1, TEMP_TOP);
        add_word(16'hFFFF, 44'h000_0000_0001, 7'd1, 1'b0, 7'd1, 1'b0,
                 TEMP_W'(TEMP_TOP - 1'b1));
        add_word(16'hFFFF, 44'h800_0000_0000, 7'd64, 1'b0, 7'd64, 1'b0, '0);
        // realistic readings, max and min moving both ways
        add_word(16'h4E59, 44'h18B_0000_0000, 7'd45, 1'b0, 7'd30, 1'b0, 19'd300 << 10);
        add_word(16'h4E59, 44'h18B_0000_1000, 7'd47, 1'b1, 7'd35, 1'b0, 19'd301 << 10);
        add_word(16'h4E59, 44'h18B_0000_2000, 7'd49, 1'b0, 7'd40, 1'b1, 19'd299 << 10);
        add_word(16'h4E59, 44'h18B_0000_3000, 7'd51, 1'b0, 7'd45, 1'b0, 19'd300 << 10);
        // alternating bit patterns
        add_word(16'h4341, 44'hAAA_AAAA_AAAA, 7'h2A, 1'b1, 7'h55, 1'b0, 19'h55555);
        add_word(16'h4341, 44'h555_5555_5555, 7'h55, 1'b0, 7'h2A, 1'b1, 19'h2AAAA);
        add_word(16'hAAAA, 44'h555_5555_5555, 7'h55, 1'b1, 7'h2A, 1'b1, 19'h2AAAA);
        add_word(16'h5555, 44'hAAA_AAAA_AAAA, 7'h2A, 1'b0, 7'h55, 1'b0, 19'h55555);
        add_word(16'hAAAA, 44'h000_0000_0000, 7'd0, 1'b0, 7'd0, 1'b0, 19'h55555);
        // humidity and cloud above 100 are summed as they are
        add_word(16'h5555, 44'h7FF_FFFF_FFFF, 7'd101, 1'b1, 7'd127, 1'b1, 19'h2AAAA);

        // random traffic: mostly known regions, now and then a new one
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (code_pool.size() == 0 || $urandom_range(0, NEW_CODE_ODDS - 1) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    code = {8'h41 + 8'($urandom_range(0, 25)),
                            8'h41 + 8'($urandom_range(0, 25))};
                else
                    code = CODE_W'($urandom());
            end
            else
            begin
                code = code_pool[$urandom_range(0, code_pool.size() - 1)];
            end
            case ($urandom_range(0, 9))
                0:       ts = '0;
                1:       ts = TIME_TOP;
                default: ts = TIME_W'({$urandom(), $urandom()});
            endcase
            hum   = ($urandom_range(0, 6) == 0) ? PCT_W'($urandom_range(0, 127))
                                                : PCT_W'($urandom_range(0, 100));
            cloud = ($urandom_range(0, 6) == 0) ? PCT_W'($urandom_range(0, 127))
                                                : PCT_W'($urandom_range(0, 100));
            case ($urandom_range(0, 9))
                0:       temp = '0;
                1:       temp = TEMP_TOP;
                2:       temp = TEMP_W'($urandom());
                3:       temp = TEMP_W'(($urandom_range(0, 3) + 280) << 10);
                default: temp = TEMP_W'($urandom_range(230 * 1024, 320 * 1024));
            endcase
            add_word(code, ts, hum, 1'($urandom()), cloud, 1'($urandom()), temp);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all words to go in and all results to come out
        while (word_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (pending_tallies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_tallies.size() == 0)
            $display("keyed_record_aggregator_test OK");
        else
            $display("keyed_record_aggregator_test NOT OK");
        $finish;
    end

endmodule
